// ===== sv/pisc_pkg.sv =====
// Shared types and constants of the PI speed controller.
package pisc_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned ERR_W     = DATA_W + 1;
	localparam int unsigned GAIN_W    = 24;
	localparam int unsigned UPPER_W   = 31;
	localparam int unsigned ACC_W     = 64;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned CFG_IDX_W = 2;

	localparam int unsigned MUL_A_W = ERR_W;
	localparam int unsigned MUL_B_W = DATA_W;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int unsigned A_W    = GAIN_W + DATA_W;
	localparam int unsigned A_HI_W = A_W - DATA_W;
	localparam int unsigned PROD_W = A_W + DATA_W;

	localparam int unsigned DIVISOR        = 1000;
	localparam int unsigned DIV_REM_W      = 10;
	localparam int unsigned DIV_RADIX_BITS = 4;
	localparam int unsigned DIV_STEPS      = PROD_W / DIV_RADIX_BITS;
	localparam int unsigned DIV_CNT_W      = $clog2(DIV_STEPS + 1);

	localparam int unsigned INC_CAP_BIT = 62;

	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = GAIN_W'(300000);
	localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = GAIN_W'(400000);
	localparam logic [UPPER_W-1:0] UPPER_RST      = UPPER_W'(1073741823);
	localparam logic [DATA_W-1:0]  LOWER_RST      = 32'hC000_0000;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_REARM  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROP_GAIN,
		CFG_INTEG_GAIN,
		CFG_UPPER_LIMIT,
		CFG_LOWER_LIMIT
	} cfg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_COMPUTED,
		STATUS_FIRST,
		STATUS_ZERO_DT
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_P,
		S_MUL_A,
		S_MUL_LO,
		S_MUL_HI,
		S_SUM,
		S_DIV_START,
		S_DIV_WAIT,
		S_ACC,
		S_ADD,
		S_CLAMP,
		S_OUT
	} pisc_state_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== sv/pisc_if.sv =====
// Valid/ready channels for sample and result transactions.
interface pisc_sample_if import pisc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [DATA_W-1:0] reference;
	logic [DATA_W-1:0] measurement;
	logic [DATA_W-1:0] time_ms;

	modport source (output valid, req_type, reference, measurement, time_ms, input ready);
	modport sink   (input valid, req_type, reference, measurement, time_ms, output ready);
endinterface

interface pisc_result_if import pisc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   control_out;
	logic [STATUS_W-1:0] status;

	modport source (output valid, control_out, status, input ready);
	modport sink   (input valid, control_out, status, output ready);
endinterface

// ===== sv/pisc_mul.sv =====
// Shared registered 33x32 unsigned multiplier.
module pisc_mul import pisc_pkg::*; (
	input  logic               clk,
	input  logic [MUL_A_W-1:0] op_a,
	input  logic [MUL_B_W-1:0] op_b,
	output logic [MUL_P_W-1:0] prod
);

	logic [MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
	end

	assign prod = prod_q;

endmodule

// ===== sv/pisc_div.sv =====
// Iterative divide by 1000, four quotient bits per cycle.
module pisc_div import pisc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam logic [DIV_REM_W:0] DIV_D = (DIV_REM_W + 1)'(DIVISOR);

	logic [PROD_W-1:0]    work_q, work_d, w;
	logic [DIV_REM_W-1:0] rem_q, rem_d, r;
	logic [DIV_REM_W:0]   t;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q, done_q;

	always_comb begin
		r = rem_q;
		w = work_q;
		t = '0;
		for (int i = 0; i < DIV_RADIX_BITS; i++) begin
			t = {r, w[PROD_W-1]};
			w = {w[PROD_W-2:0], 1'b0};
			if (t >= DIV_D) begin
				t    = t - DIV_D;
				w[0] = 1'b1;
			end
			r = t[DIV_REM_W-1:0];
		end
		work_d = w;
		rem_d  = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= work_d;
			rem_q  <= rem_d;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = work_q;

endmodule

// ===== sv/pi_speed_controller.sv =====
// PI speed controller top level: sequencer, state and configuration registers.
// A control sample runs, from acceptance until the block is ready again,
// through four passes of the shared 33x32 multiplier (proportional term,
// integral gain times error, two halves of the elapsed-time product), an 88-bit
// accumulate, a divide by 1000 at four quotient bits per cycle, then
// integrator update, sum, clamp and hand-off to the output register. A first
// sample or a zero-elapsed sample goes straight to the output hand-off; a re-arm
// gives no result. The block takes one sample at a time; the output register lets the
// next sample enter while a result still waits.
module pi_speed_controller import pisc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	pisc_sample_if.sink          samples,
	pisc_result_if.source        results,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	pisc_state_t state_q, state_d;

	logic [GAIN_W-1:0]  prop_gain_q, integ_gain_q;
	logic [UPPER_W-1:0] upper_q;
	logic [DATA_W-1:0]  lower_q;

	logic signed [ACC_W-1:0] integ_q, p_q, inc_q, sum_q;
	logic [DATA_W-1:0]       last_time_q, dt_q;
	logic                    awaiting_q;
	logic [ERR_W-1:0]        err_mag_q;
	logic                    err_neg_q;
	logic [A_HI_W-1:0]       a_hi_q;
	logic [PROD_W-1:0]       prod_q;

	logic [DATA_W-1:0]   res_ctrl_q, out_ctrl_q;
	logic [STATUS_W-1:0] res_status_q, out_status_q;
	logic                out_valid_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_prod;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	logic                    accept, out_free;
	logic [DATA_W-1:0]       dt_now;
	logic signed [ERR_W-1:0] err;
	logic [ACC_W-1:0]        p_mag;
	logic [ACC_W-1:0]        mag;
	logic signed [ACC_W-1:0] upper_ext, lower_ext;

	assign accept   = samples.valid && samples.ready;
	assign out_free = !out_valid_q || results.ready;
	assign dt_now   = samples.time_ms - last_time_q;
	assign err      = $signed({samples.reference[DATA_W-1], samples.reference})
	                - $signed({samples.measurement[DATA_W-1], samples.measurement});
	assign p_mag    = mul_prod[ACC_W-1:0];
	assign mag      = (|div_rsp.quot[PROD_W-1:INC_CAP_BIT])
	                ? (ACC_W'(1) << INC_CAP_BIT)
	                : ACC_W'(div_rsp.quot[INC_CAP_BIT-1:0]);
	assign upper_ext = $signed(ACC_W'(upper_q));
	assign lower_ext = $signed({{(ACC_W-DATA_W){lower_q[DATA_W-1]}}, lower_q});

	pisc_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (mul_prod)
	);

	pisc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d          = state_q;
		samples.ready    = 1'b0;
		mul_a            = '0;
		mul_b            = '0;
		div_req.start    = 1'b0;
		div_req.dividend = prod_q;
		unique case (state_q)
			S_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid && samples.req_type == REQ_SAMPLE) begin
					if (awaiting_q || dt_now == '0)
						state_d = S_OUT;
					else
						state_d = S_MUL_P;
				end
			end
			S_MUL_P: begin
				mul_a   = err_mag_q;
				mul_b   = MUL_B_W'(prop_gain_q);
				state_d = S_MUL_A;
			end
			S_MUL_A: begin
				mul_a   = err_mag_q;
				mul_b   = MUL_B_W'(integ_gain_q);
				state_d = S_MUL_LO;
			end
			S_MUL_LO: begin
				mul_a   = MUL_A_W'(mul_prod[DATA_W-1:0]);
				mul_b   = dt_q;
				state_d = S_MUL_HI;
			end
			S_MUL_HI: begin
				mul_a   = MUL_A_W'(a_hi_q);
				mul_b   = dt_q;
				state_d = S_SUM;
			end
			S_SUM:       state_d = S_DIV_START;
			S_DIV_START: begin
				div_req.start = 1'b1;
				state_d       = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (div_rsp.done)
					state_d = S_ACC;
			end
			S_ACC:   state_d = S_ADD;
			S_ADD:   state_d = S_CLAMP;
			S_CLAMP: state_d = S_OUT;
			S_OUT: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// configuration and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= PROP_GAIN_RST;
			integ_gain_q <= INTEG_GAIN_RST;
			upper_q      <= UPPER_RST;
			lower_q      <= LOWER_RST;
			integ_q      <= '0;
			last_time_q  <= '0;
			awaiting_q   <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_PROP_GAIN:   prop_gain_q  <= cfg_data[GAIN_W-1:0];
					CFG_INTEG_GAIN:  integ_gain_q <= cfg_data[GAIN_W-1:0];
					CFG_UPPER_LIMIT: upper_q      <= cfg_data[UPPER_W-1:0];
					CFG_LOWER_LIMIT: lower_q      <= cfg_data;
					default: ;
				endcase
			end

			if (accept) begin
				if (samples.req_type == REQ_REARM) begin
					integ_q     <= '0;
					last_time_q <= '0;
					awaiting_q  <= 1'b1;
				end else begin
					last_time_q <= samples.time_ms;
					if (awaiting_q) begin
						integ_q    <= '0;
						awaiting_q <= 1'b0;
					end
				end
			end

			if (state_q == S_ACC)
				integ_q <= integ_q + inc_q;

			if (state_q == S_CLAMP) begin
				if (sum_q > upper_ext)
					integ_q <= upper_ext - p_q;
				else if (sum_q < lower_ext)
					integ_q <= lower_ext - p_q;
			end

			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			err_neg_q    <= err[ERR_W-1];
			err_mag_q    <= err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
			dt_q         <= dt_now;
			res_ctrl_q   <= '0;
			res_status_q <= awaiting_q ? STATUS_FIRST : STATUS_ZERO_DT;
		end
		unique case (state_q)
			S_MUL_A:  p_q    <= err_neg_q ? -$signed(p_mag) : $signed(p_mag);
			S_MUL_LO: a_hi_q <= mul_prod[A_W-1:DATA_W];
			S_MUL_HI: prod_q <= PROD_W'(mul_prod[2*DATA_W-1:0]);
			S_SUM:    prod_q <= prod_q + {mul_prod[PROD_W-DATA_W-1:0], {DATA_W{1'b0}}};
			S_DIV_WAIT: begin
				if (div_rsp.done)
					inc_q <= err_neg_q ? -$signed(mag) : $signed(mag);
			end
			S_ADD:    sum_q <= p_q + integ_q;
			S_CLAMP: begin
				res_status_q <= STATUS_COMPUTED;
				if (sum_q > upper_ext)
					res_ctrl_q <= upper_ext[DATA_W-1:0];
				else if (sum_q < lower_ext)
					res_ctrl_q <= lower_q;
				else
					res_ctrl_q <= sum_q[DATA_W-1:0];
			end
			S_OUT: begin
				if (out_free) begin
					out_ctrl_q   <= res_ctrl_q;
					out_status_q <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign results.valid       = out_valid_q;
	assign results.control_out = out_ctrl_q;
	assign results.status      = out_status_q;

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV_WAIT)
		else $error("divider finished outside its wait state");

	a_rearm_sets_first: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && samples.req_type == REQ_REARM) |=> (awaiting_q && integ_q == '0))
		else $error("re-arm did not clear the controller state");

	a_first_clears_integ: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && samples.req_type == REQ_SAMPLE && awaiting_q)
		|=> (!awaiting_q && integ_q == '0 && state_q == S_OUT))
		else $error("first sample did not initialise the integrator");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && samples.req_type == REQ_SAMPLE) |=> !samples.ready)
		else $error("sample transaction accepted while one is in progress");

endmodule

// ===== bench/pisc_checker.sv =====
// Checker for the PI speed controller: predicts control outputs and compares each result.
`timescale 1ns / 100ps
module pisc_checker import pisc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	pisc_sample_if               smp,
	pisc_result_if               res,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	output int                   fail_count,
	output int                   pending,
	output int                   n_checked,
	output int                   n_clamped,
	output int                   n_rearm
);

	localparam logic [63:0] INC_CAP = 64'd1 << INC_CAP_BIT;

	typedef struct {
		logic [DATA_W-1:0] control_out;
		status_t           status;
	} drive_t;

	drive_t expected_drive[$];

	logic [GAIN_W-1:0]        kp;
	logic [GAIN_W-1:0]        ki;
	logic [UPPER_W-1:0]       ceil_lim;
	logic signed [DATA_W-1:0] floor_lim;

	longint            integ;
	logic [DATA_W-1:0] t_last;
	logic              first_pending;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
		fail_count++;
	endtask

	// Advances the controller state by one control sample and returns its drive.
	function automatic drive_t next_drive(input logic [31:0] r, input logic [31:0] m,
			input logic [31:0] t);
		logic [31:0]        dt;
		logic signed [32:0] err;
		logic [32:0]        abs_err;
		logic [63:0]        ki_err;
		logic [127:0]       quot;
		logic [63:0]        mag;
		longint             p;
		longint             inc;
		longint             sum;
		longint             ceil64;
		longint             floor64;
		drive_t             d;
		d.control_out = '0;
		if (first_pending) begin
			t_last = t;
			integ = 0;
			first_pending = 1'b0;
			d.status = STATUS_FIRST;
			return d;
		end
		dt = t - t_last;
		t_last = t;
		if (dt == 0) begin
			d.status = STATUS_ZERO_DT;
			return d;
		end
		err = $signed({r[31], r}) - $signed({m[31], m});
		abs_err = err[32] ? 33'(-err) : 33'(err);
		p = longint'(kp) * longint'(err);
		ki_err = 64'(ki) * 64'(abs_err);
		quot = (128'(ki_err) * 128'(dt)) / 128'd1000;
		mag = (quot > 128'(INC_CAP)) ? INC_CAP : quot[63:0];
		inc = err[32] ? -longint'(mag) : longint'(mag);
		integ = integ + inc;
		sum = p + integ;
		ceil64 = longint'(ceil_lim);
		floor64 = longint'(floor_lim);
		// ceiling has priority when the limits cross
		if (sum > ceil64) begin
			sum = ceil64;
			integ = ceil64 - p;
			n_clamped++;
		end else if (sum < floor64) begin
			sum = floor64;
			integ = floor64 - p;
			n_clamped++;
		end
		d.control_out = sum[31:0];
		d.status = STATUS_COMPUTED;
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_t want;
		if (!arst_n) begin
			expected_drive.delete();
			kp = PROP_GAIN_RST;
			ki = INTEG_GAIN_RST;
			ceil_lim = UPPER_RST;
			floor_lim = LOWER_RST;
			integ = 0;
			t_last = '0;
			first_pending = 1'b1;
			fail_count = 0;
			n_checked = 0;
			n_clamped = 0;
			n_rearm = 0;
			pending <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_drive.size() == 0) begin
					report_mismatch("result with none outstanding", res.control_out, '0);
				end else begin
					want = expected_drive.pop_front();
					n_checked++;
					if (res.control_out !== want.control_out)
						report_mismatch("control_out", res.control_out, want.control_out);
					if (res.status !== want.status)
						report_mismatch("status", 32'(res.status), 32'(want.status));
				end
			end
			if (cfg_wen) begin
				case (cfg_idx_t'(cfg_index))
					CFG_PROP_GAIN:   kp = cfg_data[GAIN_W-1:0];
					CFG_INTEG_GAIN:  ki = cfg_data[GAIN_W-1:0];
					CFG_UPPER_LIMIT: ceil_lim = cfg_data[UPPER_W-1:0];
					CFG_LOWER_LIMIT: floor_lim = cfg_data;
					default: ;
				endcase
			end
			if (smp.valid && smp.ready) begin
				if (smp.req_type == REQ_REARM) begin
					integ = 0;
					t_last = '0;
					first_pending = 1'b1;
					n_rearm++;
				end else begin
					expected_drive.push_back(next_drive(smp.reference, smp.measurement,
						smp.time_ms));
				end
			end
			pending <= expected_drive.size();
		end
	end

endmodule

// ===== bench/tb_pi_speed_controller.sv =====
// Testbench top for the PI speed controller: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_pi_speed_controller;
	import pisc_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;

	pisc_sample_if smp();
	pisc_result_if res();

	int          fail_count;
	int          pending;
	int          n_checked;
	int          n_clamped;
	int          n_rearm;
	int          n_sent;
	logic [31:0] now_ms;
	bit          calm;

	pi_speed_controller u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (smp),
		.results   (res),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pisc_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.smp        (smp),
		.res        (res),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.n_checked  (n_checked),
		.n_clamped  (n_clamped),
		.n_rearm    (n_rearm)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// mostly short gaps, a few long
	function automatic int gap_len();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 80);
	endfunction

	initial begin : result_sink
		int stall;
		res.ready = 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				res.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) < 2) begin
				stall = gap_len();
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input logic rq, input logic [31:0] r, input logic [31:0] m,
			input logic [31:0] t);
		smp.valid <= 1'b1;
		smp.req_type <= rq;
		smp.reference <= r;
		smp.measurement <= m;
		smp.time_ms <= t;
		do @(posedge clk); while (!smp.ready);
		n_sent++;
		if (!calm && $urandom_range(0, 9) < 3) begin
			smp.valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	task automatic sample_at(input logic [31:0] r, input logic [31:0] m, input logic [31:0] t);
		now_ms = t;
		send_item(REQ_SAMPLE, r, m, t);
	endtask

	task automatic sample_after(input logic [31:0] r, input logic [31:0] m,
			input logic [31:0] dt);
		now_ms = now_ms + dt;
		send_item(REQ_SAMPLE, r, m, now_ms);
	endtask

	task automatic rearm();
		send_item(REQ_REARM, $urandom(), $urandom(), $urandom());
	endtask

	// sender holds off until every outstanding transaction has produced its result
	task automatic hold_until_drained();
		smp.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] v);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
	endtask

	task automatic apply_gains(input logic [31:0] kp, input logic [31:0] ki,
			input logic [31:0] up, input logic [31:0] lo);
		hold_until_drained();
		write_reg(CFG_PROP_GAIN, kp);
		write_reg(CFG_INTEG_GAIN, ki);
		write_reg(CFG_UPPER_LIMIT, up);
		write_reg(CFG_LOWER_LIMIT, lo);
		cfg_wen <= 1'b0;
	endtask

	initial begin : stimulus
		int          sel;
		int          dsel;
		logic [31:0] ref_v;
		logic [31:0] meas_v;
		logic [31:0] dt;

		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		smp.valid = 1'b0;
		smp.req_type = REQ_SAMPLE;
		smp.reference = '0;
		smp.measurement = '0;
		smp.time_ms = '0;
		n_sent = 0;
		now_ms = '0;
		calm = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: first sample, zero elapsed, plain, both saturations, zero error
		sample_at(32'd1000, 32'd900, 32'd100);
		sample_at(32'd1000, 32'd900, 32'd100);
		sample_at(32'd1000, 32'd900, 32'd110);
		sample_at(32'h7FFF_FFFF, 32'h8000_0000, 32'd111);
		sample_at(32'h8000_0000, 32'h7FFF_FFFF, 32'd112);
		sample_at(32'd500, 32'd500, 32'd113);
		rearm();
		sample_at(32'd0, 32'd0, 32'd0);
		sample_at(-32'sd5, 32'd5, 32'hFFFF_FFF0);
		sample_at(32'd10, 32'd0, 32'd10);
		sample_at(32'd1, 32'd0, 32'd9);

		// widest gains and limits, capped integral increment
		apply_gains(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		sample_after(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		sample_after(32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
		rearm();
		sample_after(32'd3, 32'd1, 32'd7);

		// crossed limits: floor above ceiling
		apply_gains(32'd1, 32'd0, 32'd5, 32'd100);
		sample_after(32'd0, 32'd0, 32'd1);
		sample_after(32'd50, 32'd0, 32'd1);
		sample_after(32'd1000, 32'd0, 32'd1);

		// both limits at zero
		apply_gains(32'h00FF_FFFF, 32'h00FF_FFFF, 32'd0, 32'd0);
		sample_after(32'd3, 32'd1, 32'd5);
		sample_after(-32'sd3, 32'd1, 32'd5);

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: apply_gains(32'(PROP_GAIN_RST), 32'(INTEG_GAIN_RST), 32'(UPPER_RST),
					LOWER_RST);
				1: apply_gains(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
				2: apply_gains(32'd0, 32'd0, 32'd0, 32'd0);
				3: apply_gains($urandom_range(0, 2000), $urandom_range(0, 50000),
					$urandom_range(0, 5_000_000),
					32'(-longint'($urandom_range(0, 5_000_000))));
				default: apply_gains($urandom_range(0, 32'h00FF_FFFF),
					$urandom_range(0, 32'h00FF_FFFF), $urandom_range(0, 32'h7FFF_FFFF),
					32'(-longint'($urandom_range(0, 32'h7FFF_FFFF))));
			endcase
			calm = (phase % 3 == 2);
			for (int k = 0; k < 100; k++) begin
				sel = $urandom_range(0, 99);
				dsel = $urandom_range(0, 99);
				ref_v = $urandom();
				if (sel < 3) begin
					rearm();
				end else begin
					if (sel < 58)
						meas_v = ref_v - 32'($urandom_range(0, 4000)) + 32'd2000;
					else if (sel < 92)
						meas_v = $urandom();
					else begin
						ref_v = sel[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
						meas_v = ~ref_v;
					end
					if (dsel < 85)
						dt = $urandom_range(1, 30);
					else if (dsel < 91)
						dt = '0;
					else
						dt = $urandom();
					sample_after(ref_v, meas_v, dt);
				end
				if (k == 50 && phase == 4)
					hold_until_drained();
			end
		end

		calm = 1'b0;
		hold_until_drained();
		$display("Sent %0d sample transactions (%0d re-arms), checked %0d results, %0d clamped.",
			n_sent, n_rearm, n_checked, n_clamped);
		$display("Settings covered: reset, widest, zero, narrow, random and crossed limits.");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
